>>> design/mprq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mprq_pkg;

    localparam int KIND_W = 2;
    localparam int ID_W   = 6;
    localparam int PRIO_W = 3;
    localparam int CNT_W  = 7;

    localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_NEXT   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PICK,
        ST_EXEC,
        ST_LINK
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic pick;
        logic exec;
        logic link;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pop_hit;
    } status_t;

endpackage

`default_nettype wire

>>> design/mprq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mprq_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire mprq_pkg::status_t status,
    output mprq_pkg::cmd_t         cmd,
    output logic                   busy
);

    mprq_pkg::state_t state_reg;
    mprq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mprq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        busy        = 1'b1;
        case (state_reg)
            mprq_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = mprq_pkg::ST_PICK;
                end
            end
            mprq_pkg::ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = mprq_pkg::ST_EXEC;
            end
            mprq_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.pop_hit)
                begin
                    state_next = mprq_pkg::ST_LINK;
                end
                else
                begin
                    state_next = mprq_pkg::ST_IDLE;
                end
            end
            mprq_pkg::ST_LINK:
            begin
                cmd.link   = 1'b1;
                state_next = mprq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mprq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/mprq_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module mprq_dp
#(
    parameter int NUM_LEVELS  = 8,
    parameter int NUM_THREADS = 64
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mprq_pkg::cmd_t                 cmd,
    output mprq_pkg::status_t                   status,
    input  wire logic [mprq_pkg::KIND_W-1:0]    kind,
    input  wire logic [mprq_pkg::ID_W-1:0]      thread_id,
    input  wire logic [mprq_pkg::PRIO_W-1:0]    priority_req,
    output logic                                done,
    output logic [mprq_pkg::ID_W-1:0]           popped_id,
    output logic                                found,
    output logic                                all_empty
);

    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

    logic [mprq_pkg::KIND_W-1:0] kind_reg;
    logic [mprq_pkg::ID_W-1:0]   tid_reg;
    logic [mprq_pkg::PRIO_W-1:0] prio_reg;
    logic [LW-1:0]               lvl_reg;
    logic                        lvl_ok_reg;

    logic [mprq_pkg::CNT_W-1:0]  count_reg [NUM_LEVELS];
    logic [NUM_LEVELS-1:0]       nonempty_reg;
    logic [mprq_pkg::ID_W-1:0]   head_reg [NUM_LEVELS];
    logic [mprq_pkg::ID_W-1:0]   tail_reg [NUM_LEVELS];

    logic [mprq_pkg::ID_W-1:0]   link_mem [NUM_THREADS];
    logic [mprq_pkg::ID_W-1:0]   link_rd_reg;

    logic                        done_reg;
    logic [mprq_pkg::ID_W-1:0]   popped_reg;
    logic                        found_reg;
    logic                        all_empty_reg;

    // level selection
    logic [LW-1:0]               first_lvl;
    logic [LW-1:0]               lvl_next;
    logic                        lvl_ok_next;

    // selected level view
    logic [mprq_pkg::CNT_W-1:0]  cnt_cur;
    logic [mprq_pkg::ID_W-1:0]   head_cur;
    logic [mprq_pkg::ID_W-1:0]   tail_cur;
    logic                        is_insert;
    logic                        is_pop;
    logic                        ins_ok;
    logic                        pop_hit;
    logic [NUM_LEVELS-1:0]       nonempty_next;

    always_comb
    begin
        first_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                first_lvl = LW'(i);
            end
        end
    end

    always_comb
    begin
        lvl_next    = LW'(prio_reg);
        lvl_ok_next = 1'b0;
        case (kind_reg)
            mprq_pkg::KIND_INSERT, mprq_pkg::KIND_REMOVE:
            begin
                lvl_ok_next = (32'(prio_reg) < NUM_LEVELS);
            end
            mprq_pkg::KIND_NEXT:
            begin
                lvl_next    = first_lvl;
                lvl_ok_next = |nonempty_reg;
            end
            default:
            begin
                lvl_ok_next = 1'b0;
            end
        endcase
    end

    assign cnt_cur   = count_reg[lvl_reg];
    assign head_cur  = head_reg[lvl_reg];
    assign tail_cur  = tail_reg[lvl_reg];
    assign is_insert = (kind_reg == mprq_pkg::KIND_INSERT);
    assign is_pop    = (kind_reg == mprq_pkg::KIND_REMOVE) || (kind_reg == mprq_pkg::KIND_NEXT);
    assign ins_ok    = is_insert && lvl_ok_reg && (32'(tid_reg) < NUM_THREADS)
                       && (cnt_cur != mprq_pkg::COUNT_MAX);
    assign pop_hit   = is_pop && lvl_ok_reg && (cnt_cur != '0);

    assign status.pop_hit = pop_hit;

    always_comb
    begin
        nonempty_next = nonempty_reg;
        if (cmd.exec && ins_ok)
        begin
            nonempty_next[lvl_reg] = 1'b1;
        end
        else if (cmd.link)
        begin
            nonempty_next[lvl_reg] = (cnt_cur != mprq_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            tid_reg  <= thread_id;
            prio_reg <= priority_req;
        end
        if (cmd.pick)
        begin
            lvl_reg    <= lvl_next;
            lvl_ok_reg <= lvl_ok_next;
        end
        if (cmd.exec && ins_ok)
        begin
            if (cnt_cur == '0)
            begin
                head_reg[lvl_reg] <= tid_reg;
            end
            tail_reg[lvl_reg] <= tid_reg;
        end
        if (cmd.link && (cnt_cur > mprq_pkg::CNT_W'(1)))
        begin
            head_reg[lvl_reg] <= link_rd_reg;
        end
    end

    // next-link store
    always_ff @(posedge clk)
    begin
        if (cmd.exec && ins_ok && (cnt_cur != '0))
        begin
            link_mem[TW'(tail_cur)] <= tid_reg;
        end
        if (cmd.exec && pop_hit)
        begin
            link_rd_reg <= link_mem[TW'(head_cur)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                count_reg[i] <= '0;
            end
            nonempty_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            nonempty_reg <= nonempty_next;
            if (cmd.exec && ins_ok)
            begin
                count_reg[lvl_reg] <= cnt_cur + mprq_pkg::CNT_W'(1);
            end
            else if (cmd.link)
            begin
                count_reg[lvl_reg] <= cnt_cur - mprq_pkg::CNT_W'(1);
            end
            done_reg <= (cmd.exec && !pop_hit) || cmd.link;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((cmd.exec && !pop_hit) || cmd.link)
        begin
            popped_reg    <= cmd.link ? head_cur : '0;
            found_reg     <= cmd.link;
            all_empty_reg <= ~|nonempty_next;
        end
    end

    assign done      = done_reg;
    assign popped_id = popped_reg;
    assign found     = found_reg;
    assign all_empty = all_empty_reg;

endmodule

`default_nettype wire

>>> design/multi_priority_ready_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Multilevel ready queue: one FIFO of thread ids per priority level, level 0 highest.
// Command channel: an item (kind, thread_id, priority_req) is taken on a clock edge
// with start high and busy low. kind selects insert at tail, remove head of the
// given level, or remove head of the highest non-empty level; KIND_NONE does nothing.
// Result channel: done pulses for one cycle with popped_id, found and all_empty;
// every item gives exactly one result. The receiver cannot stall, so the result
// is simply presented for that single cycle.
// For an insert or an empty pop, done is registered as the execute state ends; for a
// pop that finds a thread, as the link state ends. busy drops in the cycle done is
// high, so the next item can be taken while the last result is shown, not before. The
// link step of a pop is there because the read of the next-link memory is registered
// before the head pointer is updated; the level pick (priority encode over the
// non-empty flags) has a state of its own.
// Reset clears the level counts and non-empty flags at once; head, tail and link
// storage need no clearing since an empty level never reads them.
module multi_priority_ready_queue_core
#(
    parameter int NUM_LEVELS  = 8,
    parameter int NUM_THREADS = 64
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [mprq_pkg::KIND_W-1:0]    kind,
    input  wire logic [mprq_pkg::ID_W-1:0]      thread_id,
    input  wire logic [mprq_pkg::PRIO_W-1:0]    priority_req,
    output logic                                done,
    output logic [mprq_pkg::ID_W-1:0]           popped_id,
    output logic                                found,
    output logic                                all_empty
);

    mprq_pkg::cmd_t    cmd;
    mprq_pkg::status_t status;

    // sequencer: capture, pick level, execute, and for a hit pop the link step
    mprq_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // pointers, counts, link memory and result registers
    mprq_dp
    #(
        .NUM_LEVELS  (NUM_LEVELS),
        .NUM_THREADS (NUM_THREADS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .thread_id    (thread_id),
        .priority_req (priority_req),
        .done         (done),
        .popped_id    (popped_id),
        .found        (found),
        .all_empty    (all_empty)
    );

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps

// Testbench for multi_priority_ready_queue_core.
// A shadow of the ready queue (per-level head, tail and count, plus one link per
// thread id) predicts the response of every item taken on the command port.
// Responses are matched in order against that prediction, field by field.
module tb;

    import mprq_pkg::*;

    localparam int LEVELS      = 8;
    localparam int THREADS     = 64;
    localparam int RANDOM_CMDS = 870;
    localparam int CYCLE_LIMIT = 200000;
    // longest path is a successful pop: its done comes from the extra link step
    localparam int SETTLE      = 10;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            hit;
        logic            empty;
    } ready_resp_t;

    // Shadow ready queue plus the responses still owed by the block.
    class ready_queue_shadow;
        bit [ID_W-1:0]  head_id [LEVELS];
        bit [ID_W-1:0]  tail_id [LEVELS];
        bit [CNT_W-1:0] depth   [LEVELS];
        bit [ID_W-1:0]  link_id [THREADS];
        ready_resp_t    owed [$];
        int unsigned    errors;

        function new();
            errors = 0;
        endfunction

        function bit levels_empty();
            foreach (depth[lv])
                if (depth[lv] != 0)
                    return 1'b0;
            return 1'b1;
        endfunction

        // pop the head of one level; a miss leaves everything as it was
        function ready_resp_t take_head(int lv);
            ready_resp_t r;
            bit [ID_W-1:0] h;
            r = '0;
            if (lv >= LEVELS || depth[lv] == 0)
                return r;
            h = head_id[lv];
            if (depth[lv] > 1)
                head_id[lv] = link_id[h];
            depth[lv] = depth[lv] - 1'b1;
            r.id  = h;
            r.hit = 1'b1;
            return r;
        endfunction

        function void apply_command(kind_t k, bit [ID_W-1:0] tid, bit [PRIO_W-1:0] lv);
            ready_resp_t r;
            int sel;
            r   = '0;
            sel = -1;
            case (k)
                KIND_INSERT:
                begin
                    if (lv < LEVELS && tid < THREADS && depth[lv] < COUNT_MAX)
                    begin
                        if (depth[lv] == 0)
                            head_id[lv] = tid;
                        else
                            link_id[tail_id[lv]] = tid;
                        tail_id[lv] = tid;
                        depth[lv]   = depth[lv] + 1'b1;
                    end
                end
                KIND_REMOVE:
                    r = take_head(lv);
                KIND_NEXT:
                begin
                    for (int i = 0; i < LEVELS; i++)
                        if (sel < 0 && depth[i] != 0)
                            sel = i;
                    if (sel >= 0)
                        r = take_head(sel);
                end
                default: ;
            endcase
            r.empty = levels_empty();
            owed.push_back(r);
        endfunction

        function void check_result(bit [ID_W-1:0] id, bit hit, bit empty);
            ready_resp_t e;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected response id %0d found %0b all_empty %0b",
                         $time, id, hit, empty);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (id !== e.id)
            begin
                $display("%0t: popped_id expected %0d actual %0d", $time, e.id, id);
                errors++;
            end
            if (hit !== e.hit)
            begin
                $display("%0t: found expected %0b actual %0b", $time, e.hit, hit);
                errors++;
            end
            if (empty !== e.empty)
            begin
                $display("%0t: all_empty expected %0b actual %0b", $time, e.empty, empty);
                errors++;
            end
        endfunction
    endclass

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    kind_t              kind         = KIND_INSERT;
    logic [ID_W-1:0]    thread_id    = '0;
    logic [PRIO_W-1:0]  priority_req = '0;
    logic               busy;
    logic               done;
    logic [ID_W-1:0]    popped_id;
    logic               found;
    logic               all_empty;

    ready_queue_shadow  sb;
    int unsigned        cycles = 0;
    bit                 steady = 1'b0;    // no sender gaps while set

    multi_priority_ready_queue_core #(
        .NUM_LEVELS  (LEVELS),
        .NUM_THREADS (THREADS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .thread_id    (thread_id),
        .priority_req (priority_req),
        .done         (done),
        .popped_id    (popped_id),
        .found        (found),
        .all_empty    (all_empty)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost response ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Everything below reads pre-edge values, so the DUT's own updates at the
    // same edge cannot race us. Note the item first, then check any response.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && busy === 1'b0)
                sb.apply_command(kind, thread_id, priority_req);
            if (done === 1'b1)
                sb.check_result(popped_id, found, all_empty);
        end
    end

    // Present one item and hold it until taken; then maybe leave a gap.
    // start is only raised here and only lowered in a later step, so a
    // back-to-back item keeps it high with a single assignment.
    task automatic issue(kind_t k, logic [ID_W-1:0] t, logic [PRIO_W-1:0] p);
        start        <= 1'b1;
        kind         <= k;
        thread_id    <= t;
        priority_req <= p;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (!steady && $urandom_range(0, 99) < 31)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Hold the command port off until every response owed has turned up.
    // Step one edge first so the item taken at the last edge is already noted.
    task automatic drain_responses();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.owed.size() != 0);
    endtask

    // Random level, but for a named remove usually steered to a level that
    // holds something so pops actually hit.
    function automatic logic [PRIO_W-1:0] remove_level();
        int lv;
        lv = $urandom_range(0, LEVELS - 1);
        if ($urandom_range(0, 99) < 80)
            for (int i = 0; i < LEVELS; i++)
                if (sb.depth[(lv + i) % LEVELS] != 0)
                    return PRIO_W'((lv + i) % LEVELS);
        return PRIO_W'(lv);
    endfunction

    initial
    begin
        int r;
        int ins_pct;
        logic [PRIO_W-1:0] lv;

        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // pops and the unused code against an empty queue
        issue(KIND_NEXT,   6'd0,  3'd0);
        issue(KIND_REMOVE, 6'd0,  3'd0);
        issue(KIND_REMOVE, 6'd63, 3'd7);
        issue(KIND_NONE,   6'd63, 3'd7);
        // extremes of id and level, one id queued on two levels
        issue(KIND_INSERT, 6'd63, 3'd7);
        issue(KIND_INSERT, 6'd0,  3'd0);
        issue(KIND_INSERT, 6'd42, 3'd0);
        issue(KIND_INSERT, 6'd21, 3'd3);
        issue(KIND_INSERT, 6'd63, 3'd3);
        issue(KIND_INSERT, 6'd5,  3'd7);
        // same id twice on one level: it links to itself
        issue(KIND_INSERT, 6'd9,  3'd2);
        issue(KIND_INSERT, 6'd9,  3'd2);
        issue(KIND_NONE,   6'd0,  3'd0);
        issue(KIND_NEXT,   6'd0,  3'd0);
        issue(KIND_REMOVE, 6'd0,  3'd0);
        issue(KIND_REMOVE, 6'd0,  3'd0);
        issue(KIND_REMOVE, 6'd0,  3'd2);
        issue(KIND_NEXT,   6'd0,  3'd0);
        issue(KIND_NEXT,   6'd0,  3'd0);
        issue(KIND_NEXT,   6'd0,  3'd0);
        issue(KIND_REMOVE, 6'd0,  3'd7);
        issue(KIND_REMOVE, 6'd0,  3'd7);
        issue(KIND_NEXT,   6'd0,  3'd0);

        // --- one level filled to its count limit; extra inserts are dropped ---
        for (int i = 0; i < 130; i++)
            issue(KIND_INSERT, ID_W'($urandom_range(0, THREADS - 1)), 3'd4);
        issue(KIND_NEXT, 6'd0, 3'd0);
        issue(KIND_INSERT, ID_W'($urandom_range(0, THREADS - 1)), 3'd4);
        issue(KIND_INSERT, ID_W'($urandom_range(0, THREADS - 1)), 3'd4);
        drain_responses();
        for (int i = 0; i < 128; i++)
            issue(KIND_REMOVE, 6'd0, 3'd4);

        // --- random ---
        // insert share swings between filling, balanced and draining phases
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            steady = (i >= 500 && i < 700);
            if (i == RANDOM_CMDS / 2)
                drain_responses();
            case ((i / 120) % 3)
                0:       ins_pct = 70;
                1:       ins_pct = 45;
                default: ins_pct = 25;
            endcase
            r = $urandom_range(0, 99);
            if (r >= 95)
                issue(KIND_NONE, ID_W'($urandom), PRIO_W'($urandom));
            else if (r < ins_pct)
            begin
                // half the inserts crowd the top three levels to build long lists
                if ($urandom_range(0, 1) == 0)
                    lv = PRIO_W'($urandom_range(0, 2));
                else
                    lv = PRIO_W'($urandom_range(0, LEVELS - 1));
                issue(KIND_INSERT, ID_W'($urandom_range(0, THREADS - 1)), lv);
            end
            else if ($urandom_range(0, 1) == 0)
                issue(KIND_REMOVE, ID_W'($urandom), remove_level());
            else
                issue(KIND_NEXT, ID_W'($urandom), PRIO_W'($urandom));
        end

        start <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
